/* design/tdbl_pkg.sv */
package tdbl_pkg;

  // defaults and fixed limits
  localparam int unsigned LABEL_COUNT_DEF = 1024;
  localparam int unsigned MAX_TREES       = 65536;

  // field widths
  localparam int NUM_W     = 16;
  localparam int LABEL_W   = 10;
  localparam int PHASE_W   = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [NUM_W-1:0] NUM_MAX = 16'hFFFF;

  // characters
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  // request kinds
  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SUPPORT = 1'b1;

  // reported phase codes
  localparam logic [PHASE_W-1:0] PHC_TREES  = 3'd0;
  localparam logic [PHASE_W-1:0] PHC_NODES  = 3'd1;
  localparam logic [PHASE_W-1:0] PHC_PARENT = 3'd2;
  localparam logic [PHASE_W-1:0] PHC_LABCNT = 3'd3;
  localparam logic [PHASE_W-1:0] PHC_LABELS = 3'd4;
  localparam logic [PHASE_W-1:0] PHC_DONE   = 3'd5;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  typedef enum logic [5:0] {
    PH_TREES   = 6'b000001,
    PH_NODES   = 6'b000010,
    PH_PARENTS = 6'b000100,
    PH_LABCNT  = 6'b001000,
    PH_LABELS  = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [NUM_W-1:0]   tree_index;
    logic [LABEL_W-1:0] largest_label;
    logic [NUM_W-1:0]   largest_node_count;
    logic               label_error;
    logic               number_overflow;
  } stat_t;

  // table operation issued in the transfer cycle
  typedef struct packed {
    logic             vld;
    logic             rd;
    logic             upd;
    logic             in_range;
    logic [NUM_W-1:0] addr;
    logic [NUM_W-1:0] tree;
  } op_t;

  // one table row
  typedef struct packed {
    logic             seen;
    logic [NUM_W-1:0] last_tree;
    logic [NUM_W-1:0] support;
  } ent_t;

  typedef struct packed {
    stat_t            stat;
    logic [NUM_W-1:0] support_value;
    logic             is_frequent;
  } rsp_t;

  function automatic logic [PHASE_W-1:0] phase_code(phase_t p);
    logic [PHASE_W-1:0] c;
    case (p)
      PH_TREES:   c = PHC_TREES;
      PH_NODES:   c = PHC_NODES;
      PH_PARENTS: c = PHC_PARENT;
      PH_LABCNT:  c = PHC_LABCNT;
      PH_LABELS:  c = PHC_LABELS;
      PH_DONE:    c = PHC_DONE;
      default:    c = PHC_TREES;
    endcase
    return c;
  endfunction

endpackage

/* design/tdbl_req_if.sv */
interface tdbl_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] text_byte;
  logic [9:0] query_label;

  modport source (output valid, req_type, text_byte, query_label, input ready);
  modport sink (input valid, req_type, text_byte, query_label, output ready);
endinterface

/* design/tdbl_rsp_if.sv */
interface tdbl_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [15:0] tree_index;
  logic [9:0]  largest_label;
  logic [15:0] largest_node_count;
  logic        label_error;
  logic        number_overflow;
  logic [15:0] support_value;
  logic        is_frequent;

  modport source (output valid, phase, tree_index, largest_label, largest_node_count,
                  label_error, number_overflow, support_value, is_frequent,
                  input ready);
  modport sink (input valid, phase, tree_index, largest_label, largest_node_count,
                label_error, number_overflow, support_value, is_frequent,
                output ready);
endinterface

/* design/tdbl_parse.sv */
module tdbl_parse #(
  parameter int unsigned LABEL_COUNT = tdbl_pkg::LABEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic                            req_type,
  input  logic [7:0]                      text_byte,
  input  logic [tdbl_pkg::LABEL_W-1:0]    query_label,
  input  logic [tdbl_pkg::LABEL_W-1:0]    label_limit,
  output tdbl_pkg::op_t                   op,
  output tdbl_pkg::stat_t                 stat
);

  localparam int NW = tdbl_pkg::NUM_W;

  tdbl_pkg::phase_t             phase, phase_next;
  logic [NW-1:0]                acc, acc_next;
  logic [NW-1:0]                trees_total, trees_total_next;
  logic [NW-1:0]                cur_tree, cur_tree_next;
  logic [NW-1:0]                items_left, items_left_next;
  logic [tdbl_pkg::LABEL_W-1:0] max_label, max_label_next;
  logic [NW-1:0]                max_nodes, max_nodes_next;
  logic                         lbl_err, lbl_err_next;
  logic                         ovf, ovf_next;

  logic          feed;
  logic          is_digit;
  logic [3:0]    digit;
  logic [19:0]   acc_x10;
  logic          acc_sat;
  logic          lbl_ok;
  logic [NW-1:0] il_dec;
  logic [NW:0]   cur_inc;
  logic          tree_end;
  logic [NW-1:0] trees_v;

  assign feed     = fire && (req_type == tdbl_pkg::REQ_FEED) && (phase != tdbl_pkg::PH_DONE);
  assign is_digit = (text_byte >= tdbl_pkg::CHAR_0) && (text_byte <= tdbl_pkg::CHAR_9);
  assign digit    = 4'(text_byte - tdbl_pkg::CHAR_0);
  assign acc_x10  = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(digit);
  assign acc_sat  = acc_x10 > 20'(tdbl_pkg::NUM_MAX);
  assign lbl_ok   = (acc <= NW'(label_limit)) && (32'(acc) < 32'(LABEL_COUNT));
  assign il_dec   = (items_left != '0) ? items_left - NW'(1) : '0;
  assign cur_inc  = (NW+1)'(cur_tree) + (NW+1)'(1);
  assign tree_end = cur_inc >= (NW+1)'(trees_total);
  assign trees_v  = (32'(acc) > 32'(tdbl_pkg::MAX_TREES)) ? NW'(tdbl_pkg::MAX_TREES) : acc;

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    trees_total_next = trees_total;
    cur_tree_next    = cur_tree;
    items_left_next  = items_left;
    max_label_next   = max_label;
    max_nodes_next   = max_nodes;
    lbl_err_next     = lbl_err;
    ovf_next         = ovf;
    if (feed) begin
      if (is_digit) begin
        if (acc_sat) begin
          acc_next = tdbl_pkg::NUM_MAX;
          ovf_next = 1'b1;
        end else begin
          acc_next = NW'(acc_x10);
        end
      end else begin
        acc_next = '0;
        case (phase)
          tdbl_pkg::PH_TREES: begin
            trees_total_next = trees_v;
            cur_tree_next    = '0;
            phase_next       = (trees_v == '0) ? tdbl_pkg::PH_DONE : tdbl_pkg::PH_NODES;
          end
          tdbl_pkg::PH_NODES: begin
            if (acc > max_nodes) max_nodes_next = acc;
            items_left_next = acc;
            phase_next      = (acc == '0) ? tdbl_pkg::PH_LABCNT : tdbl_pkg::PH_PARENTS;
          end
          tdbl_pkg::PH_PARENTS: begin
            items_left_next = il_dec;
            if (il_dec == '0) phase_next = tdbl_pkg::PH_LABCNT;
          end
          tdbl_pkg::PH_LABCNT: begin
            items_left_next = acc;
            if (acc == '0) begin
              cur_tree_next = NW'(cur_inc);
              phase_next    = tree_end ? tdbl_pkg::PH_DONE : tdbl_pkg::PH_NODES;
            end else begin
              phase_next = tdbl_pkg::PH_LABELS;
            end
          end
          tdbl_pkg::PH_LABELS: begin
            if (lbl_ok) begin
              if (acc > NW'(max_label)) max_label_next = tdbl_pkg::LABEL_W'(acc);
            end else begin
              lbl_err_next = 1'b1;
            end
            items_left_next = il_dec;
            if (il_dec == '0) begin
              cur_tree_next = NW'(cur_inc);
              phase_next    = tree_end ? tdbl_pkg::PH_DONE : tdbl_pkg::PH_NODES;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tdbl_pkg::PH_TREES;
      acc         <= '0;
      trees_total <= '0;
      cur_tree    <= '0;
      items_left  <= '0;
      max_label   <= '0;
      max_nodes   <= '0;
      lbl_err     <= 1'b0;
      ovf         <= 1'b0;
    end else begin
      phase       <= phase_next;
      acc         <= acc_next;
      trees_total <= trees_total_next;
      cur_tree    <= cur_tree_next;
      items_left  <= items_left_next;
      max_label   <= max_label_next;
      max_nodes   <= max_nodes_next;
      lbl_err     <= lbl_err_next;
      ovf         <= ovf_next;
    end
  end

  // label update goes to the table with the tree number before any increment
  always_comb begin
    op.vld      = fire;
    op.rd       = (req_type == tdbl_pkg::REQ_READ);
    op.upd      = feed && !is_digit && (phase == tdbl_pkg::PH_LABELS) && lbl_ok;
    op.in_range = 32'(query_label) < 32'(LABEL_COUNT);
    op.addr     = op.rd ? NW'(query_label) : acc;
    op.tree     = cur_tree;
  end

  always_comb begin
    stat.phase              = tdbl_pkg::phase_code(phase);
    stat.tree_index         = cur_tree;
    stat.largest_label      = max_label;
    stat.largest_node_count = max_nodes;
    stat.label_error        = lbl_err;
    stat.number_overflow    = ovf;
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == tdbl_pkg::PH_DONE) |=> (phase == tdbl_pkg::PH_DONE))
    else $error("parser left the done phase");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (lbl_err && ovf) |=> (lbl_err && ovf))
    else $error("sticky flag cleared");

endmodule

/* design/tdbl_table.sv */
module tdbl_table #(
  parameter int unsigned LABEL_COUNT = tdbl_pkg::LABEL_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tdbl_pkg::op_t                op,
  input  logic [tdbl_pkg::NUM_W-1:0]   min_support,
  output logic                         busy,
  output logic                         res_vld,
  output logic [tdbl_pkg::NUM_W-1:0]   support_value,
  output logic                         is_frequent
);

  localparam int AW = $clog2(LABEL_COUNT);
  localparam int NW = tdbl_pkg::NUM_W;

  tdbl_pkg::ent_t mem [LABEL_COUNT];
  tdbl_pkg::ent_t rd_q;
  tdbl_pkg::ent_t ent;
  tdbl_pkg::ent_t upd_ent;
  tdbl_pkg::ent_t wr_data;
  tdbl_pkg::ent_t fwd_data;

  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          s1_vld;
  logic          s1_rd;
  logic          s1_upd;
  logic          s1_in_range;
  logic [AW-1:0] s1_addr;
  logic [NW-1:0] s1_tree;
  logic          fwd_hit;
  logic          bump;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // clearing sweep after reset, one row per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(LABEL_COUNT - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      s1_vld  <= op.vld;
      fwd_hit <= bump && op.vld && (op.addr[AW-1:0] == s1_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_rd       <= op.rd;
    s1_upd      <= op.upd;
    s1_in_range <= op.in_range;
    s1_addr     <= op.addr[AW-1:0];
    s1_tree     <= op.tree;
    fwd_data    <= upd_ent;
  end

  always_ff @(posedge clk) begin
    if (op.vld) rd_q <= mem[op.addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // row written last cycle overrides the stale read
  assign ent  = fwd_hit ? fwd_data : rd_q;
  assign bump = s1_vld && s1_upd && (!ent.seen || (ent.last_tree != s1_tree));

  always_comb begin
    upd_ent.seen      = 1'b1;
    upd_ent.last_tree = s1_tree;
    upd_ent.support   = (ent.support == tdbl_pkg::NUM_MAX) ? ent.support
                                                           : ent.support + NW'(1);
  end

  assign wr_en   = clearing || bump;
  assign wr_addr = clearing ? clr_addr : s1_addr;
  assign wr_data = clearing ? '0 : upd_ent;

  assign busy          = clearing;
  assign res_vld       = s1_vld;
  assign support_value = (s1_rd && s1_in_range) ? ent.support : '0;
  assign is_frequent   = s1_rd && (support_value >= min_support);

  a_no_op_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !op.vld)
    else $error("operation during clearing sweep");

  a_bump_nonzero: assert property (@(posedge clk) disable iff (rst)
    bump |-> (upd_ent.support != '0))
    else $error("support update wrote zero");

endmodule

/* design/tdbl_outq.sv */
module tdbl_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  tdbl_pkg::rsp_t                din,
  input  logic                          rdy,
  output logic                          vld,
  output tdbl_pkg::rsp_t                dout,
  output logic [tdbl_pkg::OUTQ_CW-1:0]  level
);

  localparam int QAW = tdbl_pkg::OUTQ_AW;
  localparam int QCW = tdbl_pkg::OUTQ_CW;

  tdbl_pkg::rsp_t q [tdbl_pkg::OUTQ_DEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic           pop;

  assign vld  = (level != '0);
  assign pop  = vld && rdy;
  assign dout = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) wp <= wp + QAW'(1);
      if (pop) rp <= rp + QAW'(1);
      level <= level + QCW'(push) - QCW'(pop);
    end
  end

endmodule

/* design/tree_db_label_support_parser_core.sv */
// Label support parser for a text tree database. Bytes and label reads come in on req; every
// transfer gives exactly one result on rsp, in order. The block takes one request per clock
// while req.ready is high. The transfer cycle updates the parse registers and issues the
// table read, the next cycle receives the registered read data and writes the updated row
// back, and the result then enters a four-entry result queue. req.ready drops in two cases.
// After reset a clearing pass writes every one of the LABEL_COUNT table rows, one per cycle,
// and req.ready stays low until the pass ends (configuration writes are taken throughout).
// While rsp holds off, once the queued results plus the one in the table stage reach four,
// req.ready stays low until rsp takes a result, and rises again in the cycle after that
// transfer. Configuration goes through cfg_we, cfg_index and cfg_data: index 0 is
// label_limit, index 1 is min_support.
module tree_db_label_support_parser_core #(
  parameter int unsigned LABEL_COUNT = tdbl_pkg::LABEL_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  tdbl_req_if.sink                         req,
  tdbl_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [tdbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdbl_pkg::CFG_W-1:0]       cfg_data
);

  localparam int QCW = tdbl_pkg::OUTQ_CW;

  // configuration registers
  logic [tdbl_pkg::LABEL_W-1:0] label_limit;
  logic [tdbl_pkg::NUM_W-1:0]   min_support;

  logic                        fire;
  logic                        busy;
  logic                        res_vld;
  logic [tdbl_pkg::NUM_W-1:0]  support_value;
  logic                        is_frequent;
  logic [QCW-1:0]              level;
  tdbl_pkg::op_t               op;
  tdbl_pkg::stat_t             stat;
  tdbl_pkg::rsp_t              q_din;
  tdbl_pkg::rsp_t              q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_limit <= tdbl_pkg::LABEL_W'(1023);
      min_support <= tdbl_pkg::NUM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tdbl_pkg::REG_LABEL_LIMIT: label_limit <= cfg_data[tdbl_pkg::LABEL_W-1:0];
        tdbl_pkg::REG_MIN_SUPPORT: min_support <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a request only when not clearing and the queue has room for it and the one in the table stage
  assign req.ready = !busy && (({1'b0, level} + (QCW+1)'(res_vld))
                               < (QCW+1)'(tdbl_pkg::OUTQ_DEPTH));
  assign fire      = req.valid && req.ready;

  // parse registers and number accumulation
  tdbl_parse #(
    .LABEL_COUNT (LABEL_COUNT)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req_type    (req.req_type),
    .text_byte   (req.text_byte),
    .query_label (req.query_label),
    .label_limit (label_limit),
    .op          (op),
    .stat        (stat)
  );

  // support / last-tree table, read-modify-write in the cycle after the transfer
  tdbl_table #(
    .LABEL_COUNT (LABEL_COUNT)
  ) u_table (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .min_support   (min_support),
    .busy          (busy),
    .res_vld       (res_vld),
    .support_value (support_value),
    .is_frequent   (is_frequent)
  );

  // parse registers already hold the state after the item now in the table stage
  always_comb begin
    q_din.stat          = stat;
    q_din.support_value = support_value;
    q_din.is_frequent   = is_frequent;
  end

  tdbl_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_vld),
    .din   (q_din),
    .rdy   (rsp.ready),
    .vld   (rsp.valid),
    .dout  (q_dout),
    .level (level)
  );

  assign rsp.phase              = q_dout.stat.phase;
  assign rsp.tree_index         = q_dout.stat.tree_index;
  assign rsp.largest_label      = q_dout.stat.largest_label;
  assign rsp.largest_node_count = q_dout.stat.largest_node_count;
  assign rsp.label_error        = q_dout.stat.label_error;
  assign rsp.number_overflow    = q_dout.stat.number_overflow;
  assign rsp.support_value      = q_dout.support_value;
  assign rsp.is_frequent        = q_dout.is_frequent;

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, level} + (QCW+1)'(res_vld)) <= (QCW+1)'(tdbl_pkg::OUTQ_DEPTH)))
    else $error("result queue overrun");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.ready)
    else $error("request taken during clearing sweep");

endmodule
